// ===== src/mag_error_from_quaternion_macros.svh =====
// Assertion macros shared by the magnetometer error pipeline.
`ifndef MAG_ERROR_FROM_QUATERNION_MACROS_SVH
`define MAG_ERROR_FROM_QUATERNION_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define MEQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/meq_pkg.sv =====
// Package with widths, payload types and constants of the magnetometer error pipeline.
package meq_pkg;
    localparam int FRAC_BITS = 28;
    localparam int ROT_W     = 36;
    localparam int HW        = 22;
    localparam int HSQ_W     = 46;
    localparam int BX_W      = 23;
    localparam int ERR_W     = 36;
    localparam int SQ_STEPS  = 23;
    localparam logic signed [ROT_W-1:0] HALF_Q28 = ROT_W'(64'sd134217728);
    localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

    typedef logic signed [ROT_W-1:0] t_rot;

    typedef struct packed {
        t_rot r00, r01, r02, r10, r11, r12, r20, r21, r22;
    } t_rmat;

    typedef struct packed {
        logic signed [15:0] mx, my, mz;
    } t_mag;

    typedef struct packed {
        logic [HSQ_W-1:0] n;
        logic [BX_W-1:0]  res;
        logic [HSQ_W:0]   rem;
    } t_sq;

    // Integer division by 2^28 truncating toward zero.
    function automatic logic signed [63:0] to_counts(input logic signed [63:0] v);
        logic signed [63:0] adj;
        adj = v[63] ? v + 64'sd268435455 : v;
        return adj >>> FRAC_BITS;
    endfunction

    function automatic logic signed [ERR_W-1:0] sat(input logic signed [63:0] v);
        if (v > 64'(ERR_MAX)) return ERR_MAX;
        if (v < 64'(ERR_MIN)) return ERR_MIN;
        return v[ERR_W-1:0];
    endfunction
endpackage

// ===== src/mag_error_from_quaternion.sv =====
// Pipelined Mahony magnetometer error term from a quaternion and a raw field vector.
// Throughput: one word per cycle while the output is not stalled; the restoring square root is unrolled one
// result bit per stage (23 stages), which sets the depth of the pipeline.
// A stall on the output holds every stage in place; nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
`include "mag_error_from_quaternion_macros.svh"
module mag_error_from_quaternion
    import meq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: q_w[15:0], q_x[31:16], q_y[47:32], q_z[63:48], mag_x[79:64],
    // mag_y[95:80], mag_z[111:96]
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: err_x[35:0], err_y[71:36], err_z[107:72], zero fill [111:108]
    output logic [111:0] m_axis_tdata
);
    // Stage map: 0 products, 1 rotation matrix, 2 row products, 3 h vector,
    // 4 squares, 5 sum, 6..28 square root, 29 back rotation products,
    // 30 halfw, 31 cross products, 32 saturated output.
    localparam int NST = 33;
    localparam int SQ0 = 6;

    logic [NST-1:0] r_vld;
    logic           w_adv;
    assign w_adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // The measured vector and the rotation matrix ride along the pipe.
    t_mag  r_mag [NST];
    t_rmat r_rm  [NST];

    // Stage 0: the nine quaternion products.
    logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xx <= $signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[31:16]);
            r_yy <= $signed(s_axis_tdata[47:32]) * $signed(s_axis_tdata[47:32]);
            r_zz <= $signed(s_axis_tdata[63:48]) * $signed(s_axis_tdata[63:48]);
            r_xy <= $signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[47:32]);
            r_xz <= $signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[63:48]);
            r_yz <= $signed(s_axis_tdata[47:32]) * $signed(s_axis_tdata[63:48]);
            r_wx <= $signed(s_axis_tdata[15:0]) * $signed(s_axis_tdata[31:16]);
            r_wy <= $signed(s_axis_tdata[15:0]) * $signed(s_axis_tdata[47:32]);
            r_wz <= $signed(s_axis_tdata[15:0]) * $signed(s_axis_tdata[63:48]);
        end
    end

    // Stage 1: rotation matrix at half scale.
    t_rmat n_rm;
    always_comb begin
        n_rm.r00 = HALF_Q28 - ROT_W'(r_yy) - ROT_W'(r_zz);
        n_rm.r01 = ROT_W'(r_xy) - ROT_W'(r_wz);
        n_rm.r02 = ROT_W'(r_xz) + ROT_W'(r_wy);
        n_rm.r10 = ROT_W'(r_xy) + ROT_W'(r_wz);
        n_rm.r11 = HALF_Q28 - ROT_W'(r_xx) - ROT_W'(r_zz);
        n_rm.r12 = ROT_W'(r_yz) - ROT_W'(r_wx);
        n_rm.r20 = ROT_W'(r_xz) - ROT_W'(r_wy);
        n_rm.r21 = ROT_W'(r_yz) + ROT_W'(r_wx);
        n_rm.r22 = HALF_Q28 - ROT_W'(r_xx) - ROT_W'(r_yy);
    end

    // Carry mag and matrix along the remaining stages.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mag[0] <= {s_axis_tdata[79:64], s_axis_tdata[95:80], s_axis_tdata[111:96]};
            r_rm[1] <= n_rm;
            for (int i = 1; i < NST; i++) r_mag[i] <= r_mag[i-1];
            for (int i = 2; i < NST; i++) r_rm[i] <= r_rm[i-1];
        end
    end

    // Stage 2: products of m with the matrix rows that give h.
    logic signed [52:0] r_p [9];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p[0] <= r_mag[1].mx * r_rm[1].r00;
            r_p[1] <= r_mag[1].my * r_rm[1].r01;
            r_p[2] <= r_mag[1].mz * r_rm[1].r02;
            r_p[3] <= r_mag[1].mx * r_rm[1].r10;
            r_p[4] <= r_mag[1].my * r_rm[1].r11;
            r_p[5] <= r_mag[1].mz * r_rm[1].r12;
            r_p[6] <= r_mag[1].mx * r_rm[1].r20;
            r_p[7] <= r_mag[1].my * r_rm[1].r21;
            r_p[8] <= r_mag[1].mz * r_rm[1].r22;
        end
    end

    // Stage 3: h in integer counts.
    logic signed [HW-1:0] r_hx, r_hy, r_bz [3:NST-1];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hx <= HW'(to_counts(64'(r_p[0]) + 64'(r_p[1]) + 64'(r_p[2]) <<< 1));
            r_hy <= HW'(to_counts(64'(r_p[3]) + 64'(r_p[4]) + 64'(r_p[5]) <<< 1));
            r_bz[3] <= HW'(to_counts(64'(r_p[6]) + 64'(r_p[7]) + 64'(r_p[8]) <<< 1));
            for (int i = 4; i < NST; i++) r_bz[i] <= r_bz[i-1];
        end
    end

    // Stages 4 and 5: horizontal power.
    logic [HSQ_W-2:0] r_hxs, r_hys;
    logic [HSQ_W-1:0] r_hsq;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hxs <= (HSQ_W-1)'(r_hx * r_hx);
            r_hys <= (HSQ_W-1)'(r_hy * r_hy);
            r_hsq <= HSQ_W'(r_hxs) + HSQ_W'(r_hys);
        end
    end

    // Stages 6..28: restoring square root, one result bit per stage.
    t_sq r_sq [SQ_STEPS+1];
    always_comb r_sq[0] = '{n: r_hsq, res: '0, rem: '0};
    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
        logic [HSQ_W:0] w_rem, w_trial;
        always_comb begin
            w_rem   = {r_sq[g].rem[HSQ_W-2:0], r_sq[g].n[HSQ_W-1 -: 2]};
            w_trial = {(HSQ_W+1-BX_W-2)'(0), r_sq[g].res, 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq[g+1].n <= {r_sq[g].n[HSQ_W-3:0], 2'b00};
                if (w_rem >= w_trial) begin
                    r_sq[g+1].rem <= w_rem - w_trial;
                    r_sq[g+1].res <= {r_sq[g].res[BX_W-2:0], 1'b1};
                end else begin
                    r_sq[g+1].rem <= w_rem;
                    r_sq[g+1].res <= {r_sq[g].res[BX_W-2:0], 1'b0};
                end
            end
        end
    end

    // Stage 29: back rotation products; bx is unsigned, extend with a zero.
    localparam int BK = SQ0 + SQ_STEPS;
    logic signed [59:0] r_b [6];
    logic signed [BX_W:0] w_bx;
    assign w_bx = {1'b0, r_sq[SQ_STEPS].res};
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b[0] <= w_bx * r_rm[BK-1].r00;
            r_b[1] <= r_bz[BK-1] * r_rm[BK-1].r20;
            r_b[2] <= w_bx * r_rm[BK-1].r01;
            r_b[3] <= r_bz[BK-1] * r_rm[BK-1].r21;
            r_b[4] <= w_bx * r_rm[BK-1].r02;
            r_b[5] <= r_bz[BK-1] * r_rm[BK-1].r22;
        end
    end

    // Stage 30: halfw; a non-unit quaternion can push it past 2^24 counts.
    logic signed [HW+3:0] r_hwx, r_hwy, r_hwz;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hwx <= (HW+4)'(to_counts(64'(r_b[0]) + 64'(r_b[1])));
            r_hwy <= (HW+4)'(to_counts(64'(r_b[2]) + 64'(r_b[3])));
            r_hwz <= (HW+4)'(to_counts(64'(r_b[4]) + 64'(r_b[5])));
        end
    end

    // Stage 31: cross product terms.
    logic signed [HW+19:0] r_c [6];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c[0] <= r_mag[30].my * r_hwz;
            r_c[1] <= r_mag[30].mz * r_hwy;
            r_c[2] <= r_mag[30].mz * r_hwx;
            r_c[3] <= r_mag[30].mx * r_hwz;
            r_c[4] <= r_mag[30].mx * r_hwy;
            r_c[5] <= r_mag[30].my * r_hwx;
        end
    end

    // Stage 32: difference and saturation into the output register.
    logic [3*ERR_W-1:0] r_out;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= {sat(64'(r_c[4]) - 64'(r_c[5])),
                      sat(64'(r_c[2]) - 64'(r_c[3])),
                      sat(64'(r_c[0]) - 64'(r_c[1]))};
        end
    end
    assign m_axis_tdata = {(112-3*ERR_W)'(0), r_out};

    `MEQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `MEQ_ASSERT_IMP(a_rdy, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
    `MEQ_ASSERT_NXT(a_adv, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_vld[0])
endmodule
